// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the responder RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define GCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("responder assertion failed");

// A condition that must be followed by another in the next cycle.
`define GCR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("responder assertion failed");

`else

`define GCR_ASSERT(lbl, prop)
`define GCR_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== rtl/gcr_pkg.sv =====
// Types, codes and constant tables of the game-pad command responder.
// No dependencies; every other RTL module imports this package.
package gcr_pkg;

  // Width of a saturated response length; covers lengths up to 127.
  localparam int unsigned LEN_W = 7;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_BTN   = 2'd1;
  localparam logic [1:0] CMD_AXIS  = 2'd2;

  localparam logic [7:0] OP_STATUS   = 8'h40;
  localparam logic [7:0] OP_POLLMASK = 8'h41;
  localparam logic [7:0] OP_POLL     = 8'h42;
  localparam logic [7:0] OP_CONFIG   = 8'h43;
  localparam logic [7:0] OP_SETMODE  = 8'h44;
  localparam logic [7:0] OP_MODEL    = 8'h45;
  localparam logic [7:0] OP_ACTINFO  = 8'h46;
  localparam logic [7:0] OP_COMBO    = 8'h47;
  localparam logic [7:0] OP_MODEINFO = 8'h4C;
  localparam logic [7:0] OP_SETPOLL  = 8'h4F;

  localparam logic [7:0] ID_DIG  = 8'h41;
  localparam logic [7:0] ID_ANA  = 8'h73;
  localparam logic [7:0] ID_ANAP = 8'h79;
  localparam logic [7:0] ID_CFG  = 8'hF3;
  localparam logic [7:0] BYTE_SYNC = 8'h5A;
  localparam logic [7:0] BYTE_IDLE = 8'hFF;
  localparam logic [7:0] STICK_CENTER = 8'h7F;
  localparam logic [23:0] POLL_RESET = 24'h03FFFF;

  localparam logic [7:0] MODEL_INFO [6] = '{8'h03, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};

  localparam logic [7:0] INFO_ROWS [5][5] = '{
    '{8'h00, 8'h01, 8'h02, 8'h00, 8'h0A},
    '{8'h00, 8'h01, 8'h01, 8'h01, 8'h14},
    '{8'h00, 8'h02, 8'h00, 8'h01, 8'h00},
    '{8'h00, 8'h00, 8'h04, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h07, 8'h00, 8'h00}
  };

  // Button bit reported in each pressure byte, response bytes 9 to 20.
  localparam logic [3:0] PRESS_BIT [12] = '{
    4'd13, 4'd15, 4'd12, 4'd14, 4'd4, 4'd5, 4'd6, 4'd7, 4'd2, 4'd3, 4'd0, 4'd1
  };

  typedef enum logic [2:0] {
    K_HDR  = 3'd0,
    K_STAT = 3'd1,
    K_MASK = 3'd2,
    K_POLL = 3'd3,
    K_MODE = 3'd4,
    K_MODL = 3'd5,
    K_ROW  = 3'd6,
    K_SETP = 3'd7
  } kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  port_id;
    logic [7:0]  pad_opcode;
    logic [7:0]  arg_a;
    logic [7:0]  arg_b;
    logic [7:0]  arg_c;
    logic [8:0]  response_length;
    logic [15:0] button_mask;
    logic        pressed;
    logic [1:0]  axis_index;
    logic [7:0]  axis_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    logic [7:0] large_motor;
    logic       small_motor;
  } out_item_t;

  // One classified frame with the pad state it reads, waiting for playback.
  typedef struct packed {
    kind_e            kind;
    logic             dead;
    logic [7:0]       hdr;
    logic [2:0]       row;
    logic             dig;
    logic [23:0]      poll;
    logic [15:0]      bt;
    logic [31:0]      sticks;
    logic [LEN_W-1:0] len;
    logic [7:0]       lm;
    logic             sm;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/gcr_front.sv =====
// Front end: holds the pad state, applies updates and classifies frames.
// Depends on gcr_pkg.
module gcr_front #(
  parameter int unsigned PAD_COUNT    = 2,
  parameter int unsigned MAX_RESPONSE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  gcr_pkg::in_item_t item_i,
  output logic              push_o,
  output gcr_pkg::job_t     job_o
);
  import gcr_pkg::*;

  logic [15:0] buttons_q [2];
  logic [7:0]  mode_q [2];
  logic        cfg_q [2];
  logic [23:0] poll_q [2];
  logic [7:0]  stick_q [8];
  logic        sm_q [2];
  logic [7:0]  lm_q [2];

  logic             pad;
  logic             port_ok;
  logic [LEN_W-1:0] len;
  job_t             job;

  assign pad     = item_i.port_id[0];
  assign port_ok = ({1'b0, item_i.port_id} < 3'(PAD_COUNT));

  always_comb begin
    if (item_i.response_length > 9'(MAX_RESPONSE)) begin
      len = LEN_W'(MAX_RESPONSE);
    end else begin
      len = item_i.response_length[LEN_W-1:0];
    end
  end

  always_comb begin
    job        = '0;
    job.kind   = K_HDR;
    job.dead   = !port_ok;
    job.hdr    = cfg_q[pad] ? ID_CFG : mode_q[pad];
    job.dig    = (mode_q[pad] == ID_DIG);
    job.poll   = poll_q[pad];
    job.bt     = buttons_q[pad];
    job.sticks = {stick_q[{pad, 2'd3}], stick_q[{pad, 2'd2}],
                  stick_q[{pad, 2'd1}], stick_q[{pad, 2'd0}]};
    job.len    = len;
    job.lm     = lm_q[pad];
    job.sm     = sm_q[pad];
    unique case (item_i.pad_opcode)
      OP_STATUS:   job.kind = K_STAT;
      OP_POLLMASK: job.kind = K_MASK;
      OP_POLL: begin
        job.kind = K_POLL;
        job.lm   = item_i.arg_b;
        job.sm   = item_i.arg_a[0];
      end
      OP_SETMODE:  job.kind = K_MODE;
      OP_MODEL:    job.kind = K_MODL;
      OP_ACTINFO: begin
        job.kind = K_ROW;
        job.row  = (item_i.arg_a == 8'h00) ? 3'd0 : 3'd1;
      end
      OP_COMBO: begin
        job.kind = K_ROW;
        job.row  = 3'd2;
      end
      OP_MODEINFO: begin
        job.kind = K_ROW;
        job.row  = (item_i.arg_a == 8'h00) ? 3'd3 : 3'd4;
      end
      OP_SETPOLL:  job.kind = K_SETP;
      default:     job.kind = K_HDR;
    endcase
    if (!port_ok) begin
      job.lm = 8'h00;
      job.sm = 1'b0;
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && (item_i.command == CMD_FRAME) && (len != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        buttons_q[p] <= 16'hFFFF;
        mode_q[p]    <= ID_ANA;
        cfg_q[p]     <= 1'b0;
        poll_q[p]    <= POLL_RESET;
        sm_q[p]      <= 1'b0;
        lm_q[p]      <= 8'h00;
      end
      for (int s = 0; s < 8; s++) begin
        stick_q[s] <= STICK_CENTER;
      end
    end else if (accept_i && port_ok) begin
      unique case (item_i.command)
        CMD_BTN: begin
          if (item_i.pressed) begin
            buttons_q[pad] <= buttons_q[pad] & ~item_i.button_mask;
          end else begin
            buttons_q[pad] <= buttons_q[pad] | item_i.button_mask;
          end
        end
        CMD_AXIS: begin
          // Axis numbers 0..3 map to stick slots 2,3,0,1.
          stick_q[{pad, item_i.axis_index ^ 2'd2}] <= item_i.axis_value;
        end
        CMD_FRAME: begin
          unique case (item_i.pad_opcode)
            OP_POLL: begin
              sm_q[pad] <= item_i.arg_a[0];
              lm_q[pad] <= item_i.arg_b;
            end
            OP_CONFIG: cfg_q[pad] <= (item_i.arg_a == 8'h01);
            OP_SETMODE: mode_q[pad] <= (item_i.arg_a == 8'h01) ? ID_ANA : ID_DIG;
            OP_SETPOLL: begin
              mode_q[pad] <= ID_ANAP;
              poll_q[pad] <= {item_i.arg_c, item_i.arg_b, item_i.arg_a};
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/gcr_queue.sv =====
// Two-entry queue of classified frames between front and back end.
// Depends on gcr_pkg.
module gcr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gcr_pkg::job_t       wdata_i,
  input  logic                pop_i,
  output gcr_pkg::job_t       rdata_o,
  output gcr_pkg::q_status_t  status_o
);
  import gcr_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign rdata_o        = mem_q[rd_ptr_q];
  assign status_o.valid = (count_q != 2'd0);
  assign status_o.full  = (count_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/gcr_back.sv =====
// Back end: plays out each queued frame, one byte per unstalled cycle.
// Depends on gcr_pkg.
module gcr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gcr_pkg::job_t      head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gcr_pkg::out_item_t out_item_o
);
  import gcr_pkg::*;

  function automatic logic [7:0] byte_at(job_t j, logic [LEN_W-1:0] i);
    logic [7:0] b;
    logic [LEN_W-1:0] k;
    b = BYTE_IDLE;
    k = '0;
    if (j.dead) begin
      b = BYTE_IDLE;
    end else if (i == LEN_W'(1)) begin
      b = j.hdr;
    end else if (i == LEN_W'(2)) begin
      b = BYTE_SYNC;
    end else if (i >= LEN_W'(3)) begin
      unique case (j.kind)
        K_STAT: begin
          if (i == LEN_W'(5)) b = 8'h02;
          else if (i == LEN_W'(8)) b = BYTE_SYNC;
          else if (i <= LEN_W'(7)) b = 8'h00;
        end
        K_MASK: begin
          if (i <= LEN_W'(8)) begin
            if (j.dig) b = 8'h00;
            else if (i == LEN_W'(3)) b = j.poll[7:0];
            else if (i == LEN_W'(4)) b = j.poll[15:8];
            else if (i == LEN_W'(5)) b = j.poll[23:16];
            else if (i == LEN_W'(8)) b = BYTE_SYNC;
            else b = 8'h00;
          end
        end
        K_POLL: begin
          if (i == LEN_W'(3)) begin
            b = j.bt[15:8];
          end else if (i == LEN_W'(4)) begin
            b = j.bt[7:0];
          end else if (i <= LEN_W'(8)) begin
            if (j.len >= LEN_W'(9)) begin
              k = i - LEN_W'(5);
              b = j.sticks[{k[1:0], 3'd0} +: 8];
            end
          end else if (i <= LEN_W'(20)) begin
            if (j.len == LEN_W'(21)) begin
              k = i - LEN_W'(9);
              b = j.bt[PRESS_BIT[k[3:0]]] ? 8'h00 : 8'hFF;
            end
          end
        end
        K_MODE: begin
          if (i <= LEN_W'(4)) b = 8'h00;
          else if (i <= LEN_W'(8) && j.len == LEN_W'(9)) b = 8'h00;
        end
        K_MODL: begin
          if (i == LEN_W'(5)) begin
            b = j.dig ? 8'h00 : 8'h01;
          end else if (i <= LEN_W'(8)) begin
            k = i - LEN_W'(3);
            b = MODEL_INFO[k[2:0]];
          end
        end
        K_ROW: begin
          if (i >= LEN_W'(4) && i <= LEN_W'(8)) begin
            k = i - LEN_W'(4);
            b = INFO_ROWS[j.row][k[2:0]];
          end
        end
        K_SETP: begin
          if (i == LEN_W'(8)) b = BYTE_SYNC;
          else if (i <= LEN_W'(7)) b = 8'h00;
        end
        default: b = BYTE_IDLE;
      endcase
    end
    return b;
  endfunction

  logic [LEN_W-1:0] idx_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             load;
  logic             last;

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = (idx_q == head_i.len - LEN_W'(1));
  assign pop_o = load && last;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.resp_byte   <= byte_at(head_i, idx_q);
      out_q.resp_last   <= last;
      out_q.large_motor <= head_i.lm;
      out_q.small_motor <= head_i.sm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? '0 : idx_q + LEN_W'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/gamepad_command_responder.sv =====
// Top level of the game-pad command responder for two pads.
// Depends on gcr_pkg, gcr_front, gcr_queue, gcr_back and assert_macros.svh.
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_stall_o     in_item_i  (gcr_pkg::in_item_t)
//   output    out        out_valid_o / out_stall_i   out_item_o (gcr_pkg::out_item_t)
//
// A transaction is taken on the input channel at every cycle in which the two-entry
// frame queue is not full; button and axis updates take effect in that cycle.
// A command frame of N saturated bytes plays out one byte per cycle unless the output
// stalls, counted by the back end's byte counter; the next frame follows at once.
// Reset is asynchronous and active low; afterwards every pad is released, centered
// and in analog mode, and the block takes transactions as soon as reset is released.
// A stall on the output holds the registered byte and, once the queue fills, stalls
// the input; updates and frames are still applied strictly in arrival order.
module gamepad_command_responder #(
  parameter int unsigned PAD_COUNT    = 2,
  parameter int unsigned MAX_RESPONSE = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gcr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gcr_pkg::out_item_t out_item_o
);
  import gcr_pkg::*;

  `include "assert_macros.svh"

  logic      accept;
  logic      q_push;
  logic      q_pop;
  job_t      front_job;
  job_t      head_job;
  q_status_t q_status;

  // The front end may only take a transaction when a frame it produces has room.
  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !q_status.full;

  gcr_front #(
    .PAD_COUNT    (PAD_COUNT),
    .MAX_RESPONSE (MAX_RESPONSE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (q_push),
    .job_o    (front_job)
  );

  gcr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wdata_i  (front_job),
    .pop_i    (q_pop),
    .rdata_o  (head_job),
    .status_o (q_status)
  );

  // The back end reads the queue head in place and pops it with the final byte.
  gcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .head_valid_i (q_status.valid),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

  `GCR_ASSERT(a_no_push_full, !(q_push && q_status.full))
  `GCR_ASSERT(a_no_pop_empty, !q_pop || q_status.valid)
  `GCR_ASSERT_NEXT(a_pop_frees, q_pop && !q_push, !q_status.full)

endmodule

// ===== sim/gamepad_command_responder_checker.sv =====
// Response checker for the game-pad command responder testbench.
// Depends on gcr_pkg; watches both channels, predicts every frame and compares.
`timescale 1ns / 1ps

module gamepad_command_responder_checker #(
  parameter int unsigned PAD_COUNT    = 2,
  parameter int unsigned MAX_RESPONSE = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  gcr_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  gcr_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import gcr_pkg::*;

  localparam logic [7:0] MODEL_BYTES [6] = '{8'h03, 8'h02, 8'h00, 8'h02, 8'h01, 8'h00};
  localparam logic [7:0] INFO_TABLE [5][5] = '{
    '{8'h00, 8'h01, 8'h02, 8'h00, 8'h0A},
    '{8'h00, 8'h01, 8'h01, 8'h01, 8'h14},
    '{8'h00, 8'h02, 8'h00, 8'h01, 8'h00},
    '{8'h00, 8'h00, 8'h04, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h07, 8'h00, 8'h00}
  };
  // Button bit shown by each pressure byte, bytes 9 to 20 of a poll.
  localparam int PRESS_ORDER [12] = '{13, 15, 12, 14, 4, 5, 6, 7, 2, 3, 0, 1};

  // Pad state as the block should hold it after every accepted transaction.
  logic [15:0] btn_state    [2];
  logic [7:0]  mode_id      [2];
  logic        in_config    [2];
  logic [23:0] poll_select  [2];
  logic [7:0]  stick_val    [8];
  logic        rumble_small [2];
  logic [7:0]  rumble_large [2];

  logic [7:0]  resp_buf [MAX_RESPONSE];
  int unsigned resp_len;
  out_item_t   due_bytes [$];
  int          mismatches = 0;
  int          bytes_seen = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch at byte %0d: %s", $time, bytes_seen, what);
  endtask

  function automatic void clear_pads();
    for (int p = 0; p < 2; p++) begin
      btn_state[p]    = 16'hFFFF;
      mode_id[p]      = ID_ANA;
      in_config[p]    = 1'b0;
      poll_select[p]  = POLL_RESET;
      rumble_small[p] = 1'b0;
      rumble_large[p] = 8'h00;
    end
    for (int s = 0; s < 8; s++) stick_val[s] = STICK_CENTER;
  endfunction

  // Bytes past the saturated length are dropped.
  function automatic void put_byte(input int unsigned idx, input logic [7:0] val);
    if (idx < resp_len) resp_buf[idx] = val;
  endfunction

  function automatic void put_info_row(input int unsigned row);
    for (int k = 0; k < 5; k++) put_byte(4 + k, INFO_TABLE[row][k]);
  endfunction

  function automatic void answer_frame(input int unsigned pad, input in_item_t it);
    logic [15:0] bt;
    bt = btn_state[pad];
    put_byte(0, BYTE_IDLE);
    put_byte(1, in_config[pad] ? ID_CFG : mode_id[pad]);
    put_byte(2, BYTE_SYNC);
    case (it.pad_opcode)
      OP_STATUS: begin
        put_byte(3, 8'h00); put_byte(4, 8'h00); put_byte(5, 8'h02);
        put_byte(6, 8'h00); put_byte(7, 8'h00); put_byte(8, BYTE_SYNC);
      end
      OP_POLLMASK: begin
        if (mode_id[pad] == ID_DIG) begin
          for (int k = 3; k <= 8; k++) put_byte(k, 8'h00);
        end else begin
          put_byte(3, poll_select[pad][7:0]);
          put_byte(4, poll_select[pad][15:8]);
          put_byte(5, poll_select[pad][23:16]);
          put_byte(6, 8'h00); put_byte(7, 8'h00); put_byte(8, BYTE_SYNC);
        end
      end
      OP_POLL: begin
        put_byte(3, bt[15:8]);
        put_byte(4, bt[7:0]);
        rumble_small[pad] = it.arg_a[0];
        rumble_large[pad] = it.arg_b;
        if (resp_len >= 9) begin
          for (int k = 0; k < 4; k++) put_byte(5 + k, stick_val[pad * 4 + k]);
          // The pressure bytes appear only in a frame of exactly 21 bytes.
          if (resp_len == 21) begin
            for (int k = 0; k < 12; k++) put_byte(9 + k, bt[PRESS_ORDER[k]] ? 8'h00 : 8'hFF);
          end
        end
      end
      OP_CONFIG: in_config[pad] = (it.arg_a == 8'h01);
      OP_SETMODE: begin
        put_byte(3, 8'h00); put_byte(4, 8'h00);
        if (resp_len == 9) begin
          for (int k = 5; k <= 8; k++) put_byte(k, 8'h00);
        end
        mode_id[pad] = (it.arg_a == 8'h01) ? ID_ANA : ID_DIG;
      end
      OP_MODEL: begin
        for (int k = 0; k < 6; k++) put_byte(3 + k, MODEL_BYTES[k]);
        put_byte(5, (mode_id[pad] == ID_DIG) ? 8'h00 : 8'h01);
      end
      OP_ACTINFO:  put_info_row((it.arg_a == 8'h00) ? 0 : 1);
      OP_COMBO:    put_info_row(2);
      OP_MODEINFO: put_info_row((it.arg_a == 8'h00) ? 3 : 4);
      OP_SETPOLL: begin
        mode_id[pad] = ID_ANAP;
        for (int k = 3; k <= 7; k++) put_byte(k, 8'h00);
        put_byte(8, BYTE_SYNC);
        poll_select[pad] = {it.arg_c, it.arg_b, it.arg_a};
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_item(input in_item_t it);
    int unsigned pad;
    out_item_t   want;
    logic [7:0]  lm;
    logic        sm;
    pad = it.port_id[0];
    case (it.command)
      CMD_BTN: begin
        if (it.port_id < PAD_COUNT) begin
          if (it.pressed) btn_state[pad] = btn_state[pad] & ~it.button_mask;
          else btn_state[pad] = btn_state[pad] | it.button_mask;
        end
      end
      CMD_AXIS: begin
        // Axis numbers swap halves: 0,1,2,3 land in slots 2,3,0,1.
        if (it.port_id < PAD_COUNT)
          stick_val[pad * 4 + int'(it.axis_index ^ 2'd2)] = it.axis_value;
      end
      CMD_FRAME: begin
        resp_len = (it.response_length > MAX_RESPONSE) ? MAX_RESPONSE : it.response_length;
        for (int k = 0; k < MAX_RESPONSE; k++) resp_buf[k] = BYTE_IDLE;
        lm = 8'h00;
        sm = 1'b0;
        if (it.port_id < PAD_COUNT) begin
          answer_frame(pad, it);
          lm = rumble_large[pad];
          sm = rumble_small[pad];
        end
        for (int unsigned k = 0; k < resp_len; k++) begin
          want.resp_byte   = resp_buf[k];
          want.resp_last   = (k + 1 == resp_len);
          want.large_motor = lm;
          want.small_motor = sm;
          due_bytes.insert(due_bytes.size(), want);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (due_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %h arrived with nothing outstanding", got.resp_byte));
    end else begin
      want = due_bytes[0];
      due_bytes.delete(0);
      if (got.resp_byte !== want.resp_byte)
        report_mismatch($sformatf("resp_byte %h, wanted %h", got.resp_byte, want.resp_byte));
      if (got.resp_last !== want.resp_last)
        report_mismatch($sformatf("resp_last %b, wanted %b", got.resp_last, want.resp_last));
      if (got.large_motor !== want.large_motor)
        report_mismatch($sformatf("large_motor %h, wanted %h", got.large_motor,
                                  want.large_motor));
      if (got.small_motor !== want.small_motor)
        report_mismatch($sformatf("small_motor %b, wanted %b", got.small_motor,
                                  want.small_motor));
    end
    bytes_seen++;
  endtask

  // Results are compared before the new transaction is predicted, since a byte
  // leaving at this edge always belongs to an earlier frame.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_pads();
      due_bytes.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_byte(out_item_i);
      if (in_valid_i && !in_stall_i) predict_item(in_item_i);
      pending_o <= due_bytes.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// ===== sim/gamepad_command_responder_test.sv =====
// Testbench top for the game-pad command responder: clock, reset and stimulus.
// Depends on gcr_pkg, the responder RTL and gamepad_command_responder_checker.
`timescale 1ns / 1ps

module gamepad_command_responder_test;
  import gcr_pkg::*;

  localparam int unsigned PADS    = 2;
  localparam int unsigned MAX_LEN = 32;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Opcodes the pad understands; random frames mostly draw from these.
  localparam logic [7:0] KNOWN_OPS [10] = '{
    OP_STATUS, OP_POLLMASK, OP_POLL, OP_CONFIG, OP_SETMODE,
    OP_MODEL, OP_ACTINFO, OP_COMBO, OP_MODEINFO, OP_SETPOLL
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_valid    = 1'b0;
  logic         in_stall;
  in_item_t     in_item     = '0;
  logic         out_valid;
  logic         out_stall   = 1'b0;
  out_item_t    out_item;
  int           fail_count;
  int           pending;

  // Sender and receiver pacing.
  stall_style_e stall_style   = STALL_NONE;
  logic         hold_request  = 1'b0;
  logic         hold_taken    = 1'b0;
  int unsigned  hold_left     = 0;
  logic [2:0]   stall_phase   = '0;
  int unsigned  burst_left    = 0;
  bit           sender_steady = 1'b0;

  always #5 clk = ~clk;

  gamepad_command_responder #(
    .PAD_COUNT   (PADS),
    .MAX_RESPONSE(MAX_LEN)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  gamepad_command_responder_checker #(
    .PAD_COUNT   (PADS),
    .MAX_RESPONSE(MAX_LEN)
  ) checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver stalls according to the current style. A long hold-off, once
  // requested by the stimulus, is taken once and counted down here; during it
  // the frame queue fills and the block has to stall its input while the
  // sender keeps offering.
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= 400;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 3'd1;
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_phase >= 3'd5);
      endcase
    end
  end

  // Every field gets random bits first, so that bits a transaction does not use
  // still toggle; the fields that matter are then overwritten.
  function automatic in_item_t random_item();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t frame_item(input logic [1:0] port, input logic [7:0] op,
                                          input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [8:0] len);
    in_item_t it;
    it                 = random_item();
    it.command         = CMD_FRAME;
    it.port_id         = port;
    it.pad_opcode      = op;
    it.arg_a           = a;
    it.arg_b           = b;
    it.arg_c           = c;
    it.response_length = len;
    return it;
  endfunction

  function automatic in_item_t button_item(input logic [1:0] port, input logic [15:0] mask,
                                           input logic down);
    in_item_t it;
    it             = random_item();
    it.command     = CMD_BTN;
    it.port_id     = port;
    it.button_mask = mask;
    it.pressed     = down;
    return it;
  endfunction

  function automatic in_item_t axis_item(input logic [1:0] port, input logic [1:0] idx,
                                         input logic [7:0] val);
    in_item_t it;
    it            = random_item();
    it.command    = CMD_AXIS;
    it.port_id    = port;
    it.axis_index = idx;
    it.axis_value = val;
    return it;
  endfunction

  // A transaction with the command code that the block ignores.
  function automatic in_item_t unused_item();
    in_item_t it;
    it         = random_item();
    it.command = CMD_UNUSED;
    return it;
  endfunction

  // Lengths cluster on the interesting values: zero, short, 9, 21 and saturation.
  function automatic logic [8:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1, 2:    return 9'd21;
      3, 4:    return 9'd9;
      5:       return 9'(MAX_LEN);
      6:       return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  // Arguments are often 0 or 1, the values that select modes and rows.
  function automatic logic [7:0] pick_arg();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] pick_pad_port();
    return ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
  endfunction

  // Offers one transaction and waits for the edge that accepts it. Between
  // bursts the sender drops valid for a random gap unless it runs steady.
  task automatic send(input in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap        = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // A well-formed configuration session: enter, a few config commands, leave.
  task automatic config_session(input logic [1:0] port, inout int unsigned count);
    int unsigned steps;
    logic [7:0]  op;
    send(frame_item(port, OP_CONFIG, 8'h01, pick_arg(), pick_arg(), 9'd9));
    steps = $urandom_range(1, 3);
    for (int k = 0; k < steps; k++) begin
      op = KNOWN_OPS[$urandom_range(4, 9)];
      send(frame_item(port, op, pick_arg(), 8'($urandom), 8'($urandom),
                      ($urandom_range(0, 2) == 0) ? pick_length() : 9'd9));
    end
    send(frame_item(port, OP_CONFIG, 8'h00, pick_arg(), pick_arg(), pick_length()));
    count += steps + 2;
  endtask

  initial begin
    int unsigned count;
    int unsigned phase_left;
    int unsigned choice;
    int unsigned wait_cycles;
    bit          hold_done;
    logic [1:0]  port;
    logic [7:0]  op;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: fresh pad poll, button and stick changes, every opcode,
    // the config-only queries, short and zero lengths, saturation, unused port.
    stall_style <= STALL_LIGHT;
    send(frame_item(2'd0, OP_POLL, 8'h00, 8'h00, 8'h00, 9'd21));
    send(button_item(2'd0, 16'hA5A5, 1'b1));
    send(axis_item(2'd0, 2'd0, 8'h00));
    send(axis_item(2'd0, 2'd3, 8'hFF));
    send(frame_item(2'd0, OP_POLL, 8'h01, 8'hFF, 8'h00, 9'd21));
    send(frame_item(2'd1, OP_POLL, 8'hFE, 8'h80, 8'hFF, 9'd9));
    send(frame_item(2'd0, OP_POLL, 8'h00, 8'h40, 8'h00, 9'd5));
    send(frame_item(2'd0, OP_MODEL, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_CONFIG, 8'h01, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_ACTINFO, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_ACTINFO, 8'h01, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_COMBO, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_MODEINFO, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_MODEINFO, 8'h01, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_SETMODE, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_POLLMASK, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_SETPOLL, 8'h12, 8'h34, 8'h56, 9'd9));
    send(frame_item(2'd1, OP_CONFIG, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd1, OP_POLLMASK, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd0, OP_STATUS, 8'h00, 8'h00, 8'h00, 9'd9));
    send(frame_item(2'd0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 9'd3));
    send(frame_item(2'd2, OP_POLL, 8'h01, 8'hFF, 8'h00, 9'd9));
    send(button_item(2'd3, 16'hFFFF, 1'b1));
    send(frame_item(2'd0, OP_POLL, 8'h00, 8'h00, 8'h00, 9'd0));
    send(frame_item(2'd1, OP_POLL, 8'h00, 8'h00, 8'h00, 9'd511));
    send(unused_item());

    // Random part. The first phase runs with no idling on either side; later
    // phases mix styles, and one long receiver hold-off is raised midway.
    count         = 0;
    phase_left    = 20;
    hold_done     = 1'b0;
    sender_steady = 1'b1;
    stall_style   <= STALL_NONE;
    while (count < 95) begin
      if (phase_left == 0) begin
        phase_left    = $urandom_range(15, 30);
        sender_steady = ($urandom_range(0, 2) == 0);
        stall_style   <= stall_style_e'($urandom_range(0, 3));
      end
      if (!hold_done && count >= 50) begin
        hold_done     = 1'b1;
        sender_steady = 1'b1;
        hold_request  <= 1'b1;
      end
      choice = $urandom_range(0, 99);
      port   = pick_pad_port();
      if (choice < 15) begin
        config_session(port, count);
      end else if (choice < 45) begin
        op = ($urandom_range(0, 4) == 0) ? 8'($urandom) : KNOWN_OPS[$urandom_range(0, 9)];
        send(frame_item(port, op, pick_arg(), 8'($urandom), 8'($urandom), pick_length()));
        count++;
      end else if (choice < 55) begin
        send(frame_item(port, OP_POLL, 8'($urandom), 8'($urandom), pick_arg(), 9'd21));
        count++;
      end else if (choice < 72) begin
        send(button_item(port, 16'($urandom), 1'($urandom)));
        if (port < PADS) count++;
      end else if (choice < 90) begin
        send(axis_item(port, 2'($urandom), 8'($urandom)));
        if (port < PADS) count++;
      end else begin
        // The ignored command code does not count.
        send(unused_item());
      end
      if (phase_left != 0) phase_left--;
    end

    if (in_valid) in_valid <= 1'b0;
    stall_style <= STALL_LIGHT;
    @(posedge clk);
    for (wait_cycles = 0; wait_cycles < 20000 && pending != 0; wait_cycles++) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("gamepad_command_responder_test OK");
    end else begin
      $display("gamepad_command_responder_test NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("gamepad_command_responder_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gcr_pkg.sv
rtl/gcr_front.sv
rtl/gcr_queue.sv
rtl/gcr_back.sv
rtl/gamepad_command_responder.sv
sim/gamepad_command_responder_checker.sv
sim/gamepad_command_responder_test.sv
